// ----- rtl/vefm_pkg.sv -----
// Package for the voxel exposed-face mask: item codes, widths, face order,
// neighbour row selects and the controller/datapath command and status types.
// No dependencies.
`default_nettype none

package vefm_pkg;

   localparam int GRID_SIZE_DEF = 32;

   localparam int COORD_W  = 5;
   localparam int EXTENT_W = 6;
   localparam int MASK_W   = 6;
   localparam int CW       = COORD_W + 2;   // coordinate plus room for +/-1 and grid compare

   localparam logic [EXTENT_W-1:0] SCAN_EXTENT_RESET = 6'd32;

   typedef enum logic [1:0] {
      CMD_WRITE = 2'd0,
      CMD_FILL  = 2'd1,
      CMD_QUERY = 2'd2
   } cmd_type;

   // face bit positions
   localparam int FACE_XP = 0;
   localparam int FACE_XM = 1;
   localparam int FACE_YP = 2;
   localparam int FACE_YM = 3;
   localparam int FACE_ZP = 4;
   localparam int FACE_ZM = 5;

   // row selects: each memory row holds one (x, y) column along z
   localparam int NB_COUNT = 5;
   localparam int NB_W     = $clog2(NB_COUNT);
   localparam logic [NB_W-1:0] NB_CENTRE = 3'd0;
   localparam logic [NB_W-1:0] NB_XP     = 3'd1;
   localparam logic [NB_W-1:0] NB_XM     = 3'd2;
   localparam logic [NB_W-1:0] NB_YP     = 3'd3;
   localparam logic [NB_W-1:0] NB_YM     = 3'd4;
   localparam logic [NB_W-1:0] NB_LAST   = NB_YM;

   typedef struct packed {
      logic            load;
      logic            rd_en;
      logic [NB_W-1:0] rd_sel;
      logic            sweep_en;
      logic            sweep_fill;
      logic            row_wr;
      logic            rsp_load;
   } ctrl_cmd_type;

   typedef struct packed {
      cmd_type req_cmd;
      cmd_type item_cmd;
      logic    sweep_last;
      logic    rsp_free;
   } ctrl_stat_type;

endpackage

`default_nettype wire

// ----- rtl/vefm_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module vefm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ----- rtl/vefm_ctrl.sv -----
// Controller for the voxel exposed-face mask: clear pass, fill sweep, row reads,
// read-modify-write and result hand-off. Depends on vefm_pkg.
`default_nettype none

module vefm_ctrl import vefm_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   input  wire ctrl_stat_type stat,
   output ctrl_cmd_type       cmd
);

   typedef enum logic [6:0] {
      ST_CLEAR = 7'b0000001,
      ST_IDLE  = 7'b0000010,
      ST_FILL  = 7'b0000100,
      ST_READ  = 7'b0001000,
      ST_WAIT  = 7'b0010000,
      ST_WRITE = 7'b0100000,
      ST_REPLY = 7'b1000000
   } state_type;

   state_type       state_ff, state_in;
   logic [NB_W-1:0] step_ff, step_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         step_ff  <= NB_CENTRE;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cmd      = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.sweep_en = 1'b1;
            if (stat.sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            step_in   = NB_CENTRE;
            if (req_valid) begin
               cmd.load = 1'b1;
               case (stat.req_cmd)
                  CMD_WRITE, CMD_QUERY: state_in = ST_READ;
                  CMD_FILL:             state_in = ST_FILL;
                  default:              state_in = ST_IDLE;
               endcase
            end
         end
         ST_FILL: begin
            cmd.sweep_en   = 1'b1;
            cmd.sweep_fill = 1'b1;
            if (stat.sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_READ: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = step_ff;
            if (stat.item_cmd == CMD_WRITE || step_ff == NB_LAST) begin
               step_in  = NB_CENTRE;
               state_in = ST_WAIT;
            end else begin
               step_in = step_ff + NB_W'(1);
            end
         end
         ST_WAIT: begin
            state_in = (stat.item_cmd == CMD_WRITE) ? ST_WRITE : ST_REPLY;
         end
         ST_WRITE: begin
            cmd.row_wr = 1'b1;
            state_in   = ST_IDLE;
         end
         ST_REPLY: begin
            if (stat.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- rtl/vefm_datapath.sv -----
// Datapath for the voxel exposed-face mask: item and extent registers, row
// addressing, grid RAM, neighbour rows, face logic and result register.
// Depends on vefm_pkg and vefm_ram.
`default_nettype none

module vefm_datapath import vefm_pkg::*; #(
   parameter int GRID_SIZE = GRID_SIZE_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_wr_en,
   input  wire logic [EXTENT_W-1:0] csr_wr_data,
   input  wire logic [1:0]          req_cmd,
   input  wire logic [COORD_W-1:0]  req_coord_x,
   input  wire logic [COORD_W-1:0]  req_coord_y,
   input  wire logic [COORD_W-1:0]  req_coord_z,
   input  wire logic                req_occupied_bit,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [MASK_W-1:0]        rsp_face_mask,
   output logic                     rsp_voxel_present,
   input  wire ctrl_cmd_type        cmd,
   output ctrl_stat_type            stat
);

   localparam int DEPTH = GRID_SIZE * GRID_SIZE;
   localparam int AW    = $clog2(DEPTH);
   localparam int ZW    = $clog2(GRID_SIZE);
   localparam logic [CW-1:0] GRID_LIM = CW'(GRID_SIZE);
   localparam logic [AW-1:0] SWEEP_END = AW'(DEPTH - 1);

   cmd_type              cmd_ff;
   logic [COORD_W-1:0]   x_ff, y_ff, z_ff;
   logic                 bit_ff;
   logic [EXTENT_W-1:0]  ext_ff, ext_in;
   logic [AW-1:0]        sweep_cnt_ff, sweep_cnt_in;
   logic                 rd_pend_ff, rd_ok_ff;
   logic [NB_W-1:0]      rd_sel_ff;
   logic [GRID_SIZE-1:0] row_ff [NB_COUNT];
   logic [GRID_SIZE-1:0] row_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [MASK_W-1:0]    mask_ff;
   logic                 present_ff;

   logic [CW-1:0]        xw, yw, zw, ew, nx, ny, zp, zm;
   logic [ZW-1:0]        z_idx, zp_idx, zm_idx;
   logic                 nb_ok, in_grid, present;
   logic [AW-1:0]        rd_addr, c_addr;
   logic [GRID_SIZE-1:0] rd_data, bit_sel, new_row;
   logic [MASK_W-1:0]    faces, face_mask;
   logic                 ram_wr_en;
   logic [AW-1:0]        ram_wr_addr;
   logic [GRID_SIZE-1:0] ram_wr_data;

   assign xw = {{(CW-COORD_W){1'b0}}, x_ff};
   assign yw = {{(CW-COORD_W){1'b0}}, y_ff};
   assign zw = {{(CW-COORD_W){1'b0}}, z_ff};
   assign ew = {{(CW-EXTENT_W){1'b0}}, ext_ff};
   assign zp = zw + CW'(1);
   assign zm = zw - CW'(1);
   assign z_idx  = ZW'(zw);
   assign zp_idx = ZW'(zp);
   assign zm_idx = ZW'(zm);

   assign in_grid = (xw < GRID_LIM) && (yw < GRID_LIM) && (zw < GRID_LIM);

   always_comb begin
      nx = xw;
      ny = yw;
      case (cmd.rd_sel)
         NB_XP:   nx = xw + CW'(1);
         NB_XM:   nx = xw - CW'(1);
         NB_YP:   ny = yw + CW'(1);
         NB_YM:   ny = yw - CW'(1);
         default: begin
            nx = xw;
            ny = yw;
         end
      endcase
   end

   assign nb_ok   = (nx < GRID_LIM) && (ny < GRID_LIM);
   assign rd_addr = nb_ok ? AW'(32'(nx) * GRID_SIZE + 32'(ny)) : '0;
   assign c_addr  = AW'(32'(xw) * GRID_SIZE + 32'(yw));

   // read-modify-write of the centre row
   assign bit_sel = {{(GRID_SIZE-1){1'b0}}, 1'b1} << z_idx;
   assign new_row = bit_ff ? (row_ff[NB_CENTRE] | bit_sel) : (row_ff[NB_CENTRE] & ~bit_sel);

   assign ram_wr_en   = cmd.sweep_en | (cmd.row_wr & in_grid);
   assign ram_wr_addr = cmd.sweep_en ? sweep_cnt_ff : c_addr;
   assign ram_wr_data = cmd.sweep_en ? {GRID_SIZE{cmd.sweep_fill}} : new_row;

   vefm_ram #(
      .WIDTH (GRID_SIZE),
      .DEPTH (DEPTH)
   ) u_grid (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // rows outside the grid read as empty
   assign row_in = rd_ok_ff ? rd_data : '0;

   assign present = in_grid && (xw < ew) && (yw < ew) && (zw < ew) &&
                    row_ff[NB_CENTRE][z_idx];

   always_comb begin
      faces          = '0;
      faces[FACE_XP] = !row_ff[NB_XP][z_idx];
      faces[FACE_XM] = !row_ff[NB_XM][z_idx];
      faces[FACE_YP] = !row_ff[NB_YP][z_idx];
      faces[FACE_YM] = !row_ff[NB_YM][z_idx];
      faces[FACE_ZP] = !((zp < GRID_LIM) && row_ff[NB_CENTRE][zp_idx]);
      faces[FACE_ZM] = !((zm < GRID_LIM) && row_ff[NB_CENTRE][zm_idx]);
   end

   assign face_mask = present ? faces : '0;

   always_comb begin
      ext_in = csr_wr_en ? csr_wr_data : ext_ff;
      sweep_cnt_in = sweep_cnt_ff;
      if (cmd.sweep_en) begin
         sweep_cnt_in = (sweep_cnt_ff == SWEEP_END) ? '0 : sweep_cnt_ff + AW'(1);
      end
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ext_ff       <= SCAN_EXTENT_RESET;
         sweep_cnt_ff <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ext_ff       <= ext_in;
         sweep_cnt_ff <= sweep_cnt_in;
         rd_pend_ff   <= cmd.rd_en;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff <= cmd_type'(req_cmd);
         x_ff   <= req_coord_x;
         y_ff   <= req_coord_y;
         z_ff   <= req_coord_z;
         bit_ff <= req_occupied_bit;
      end
      rd_sel_ff <= cmd.rd_sel;
      rd_ok_ff  <= nb_ok;
      if (rd_pend_ff) begin
         row_ff[rd_sel_ff] <= row_in;
      end
      if (cmd.rsp_load) begin
         mask_ff    <= face_mask;
         present_ff <= present;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_face_mask     = mask_ff;
   assign rsp_voxel_present = present_ff;

   assign stat.req_cmd    = cmd_type'(req_cmd);
   assign stat.item_cmd   = cmd_ff;
   assign stat.sweep_last = (sweep_cnt_ff == SWEEP_END);
   assign stat.rsp_free   = !rsp_valid_ff || !rsp_stall;

endmodule

`default_nettype wire

// ----- rtl/voxel_exposed_face_mask.sv -----
// Voxel exposed-face mask, top level. Query: five row reads through the grid RAM's
// one read port, then the result is registered once the result register is free;
// no new item is taken until the current one is done. Write: read-modify-write of
// one row. Fill: one row written per cycle over GRID_SIZE^2 rows. After reset a clearing
// pass over GRID_SIZE^2 rows (1024 by default) zeroes the grid with req_stall high;
// csr writes are taken throughout. Depends on vefm_pkg, vefm_ctrl and vefm_datapath.
`default_nettype none

module voxel_exposed_face_mask import vefm_pkg::*; #(
   parameter int GRID_SIZE = GRID_SIZE_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_wr_en,
   input  wire logic [EXTENT_W-1:0] csr_wr_data,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [1:0]          req_cmd,
   input  wire logic [COORD_W-1:0]  req_coord_x,
   input  wire logic [COORD_W-1:0]  req_coord_y,
   input  wire logic [COORD_W-1:0]  req_coord_z,
   input  wire logic                req_occupied_bit,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [MASK_W-1:0]        rsp_face_mask,
   output logic                     rsp_voxel_present
);

   ctrl_cmd_type  ctrl_cmd;
   ctrl_stat_type ctrl_stat;

   vefm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (ctrl_stat),
      .cmd       (ctrl_cmd)
   );

   vefm_datapath #(
      .GRID_SIZE (GRID_SIZE)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_cmd           (req_cmd),
      .req_coord_x       (req_coord_x),
      .req_coord_y       (req_coord_y),
      .req_coord_z       (req_coord_z),
      .req_occupied_bit  (req_occupied_bit),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_face_mask     (rsp_face_mask),
      .rsp_voxel_present (rsp_voxel_present),
      .cmd               (ctrl_cmd),
      .stat              (ctrl_stat)
   );

   // clearing pass holds off items right after reset
   a_clear_stalls: assert property (@(posedge clock)
      $fell(reset) |-> req_stall)
      else $error("item taken during clearing pass");

   // a waiting result is never overwritten
   a_rsp_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ctrl_cmd.rsp_load |-> (!rsp_valid || !rsp_stall))
      else $error("result register overwritten while stalled");

   // sweep and row write never share the RAM write port
   a_wr_port_excl: assert property (@(posedge clock) disable iff (reset)
      ctrl_cmd.row_wr |-> !ctrl_cmd.sweep_en)
      else $error("row write during sweep");

   // input side is closed during the row reads of a query or a write
   a_busy_stall: assert property (@(posedge clock) disable iff (reset)
      ctrl_cmd.rd_en |-> req_stall)
      else $error("item accepted during row reads");

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// Testbench for voxel_exposed_face_mask: directed and random write, fill and query items
// checked against a behavioural occupancy grid, with random gaps and stalls on both sides.
// Depends on vefm_pkg and the RTL of voxel_exposed_face_mask.
module testbench;
   import vefm_pkg::*;

   localparam int GRID          = GRID_SIZE_DEF;
   localparam int CELLS         = GRID * GRID * GRID;
   localparam int SETTLE_CYCLES = GRID * GRID + 64;   // a fill may still be running
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   typedef struct packed {
      logic [1:0]         cmd;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] z;
      logic               occ;
   } req_item_type;

   typedef struct packed {
      logic [MASK_W-1:0] mask;
      logic              present;
   } face_result_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_wr_en = 1'b0;
   logic [EXTENT_W-1:0] csr_wr_data = '0;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [1:0]          req_cmd = '0;
   logic [COORD_W-1:0]  req_coord_x = '0;
   logic [COORD_W-1:0]  req_coord_y = '0;
   logic [COORD_W-1:0]  req_coord_z = '0;
   logic                req_occupied_bit = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [MASK_W-1:0]   rsp_face_mask;
   logic                rsp_voxel_present;

   voxel_exposed_face_mask dut (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_cmd           (req_cmd),
      .req_coord_x       (req_coord_x),
      .req_coord_y       (req_coord_y),
      .req_coord_z       (req_coord_z),
      .req_occupied_bit  (req_occupied_bit),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_face_mask     (rsp_face_mask),
      .rsp_voxel_present (rsp_voxel_present)
   );

   always #5 clock = ~clock;

   bit              occupancy [CELLS];
   int unsigned     scan_extent = 32'(SCAN_EXTENT_RESET);
   req_item_type    req_items [$];
   face_result_type face_results [$];
   req_item_type    on_bus;
   int              errors, n_pushed, n_items, n_queries, n_present, n_writes, n_fills, n_phases;
   bit              req_gaps_on = 1'b1;
   bit              rsp_stalls_on = 1'b1;
   int              req_gap, rsp_hold;

   function automatic int pick_idle(bit enabled);
      int r;
      r = $urandom_range(99);
      if (!enabled || r < 55) return 0;
      if (r < 90) return $urandom_range(3, 1);
      if (r < 98) return $urandom_range(12, 4);
      return $urandom_range(60, 20);
   endfunction

   function automatic int grid_index(int x, int y, int z);
      return (x * GRID + y) * GRID + z;
   endfunction

   function automatic bit solid(int x, int y, int z);
      if (x < 0 || x >= GRID || y < 0 || y >= GRID || z < 0 || z >= GRID) return 1'b0;
      return occupancy[grid_index(x, y, z)];
   endfunction

   // grid update and expected faces for one accepted item
   function automatic void apply_command(req_item_type it);
      face_result_type r;
      int x, y, z;
      bit in_grid;
      x = int'(it.x);
      y = int'(it.y);
      z = int'(it.z);
      in_grid = x < GRID && y < GRID && z < GRID;
      r = '0;
      n_items++;
      case (it.cmd)
         CMD_WRITE: begin
            n_writes++;
            if (in_grid) occupancy[grid_index(x, y, z)] = it.occ;
         end
         CMD_FILL: begin
            n_fills++;
            foreach (occupancy[i]) occupancy[i] = 1'b1;
         end
         CMD_QUERY: begin
            n_queries++;
            if (in_grid && x < scan_extent && y < scan_extent && z < scan_extent &&
                occupancy[grid_index(x, y, z)]) begin
               n_present++;
               r.present       = 1'b1;
               r.mask[FACE_XP] = !solid(x + 1, y, z);
               r.mask[FACE_XM] = !solid(x - 1, y, z);
               r.mask[FACE_YP] = !solid(x, y + 1, z);
               r.mask[FACE_YM] = !solid(x, y - 1, z);
               r.mask[FACE_ZP] = !solid(x, y, z + 1);
               r.mask[FACE_ZM] = !solid(x, y, z - 1);
            end
            face_results.push_back(r);
         end
         default: ;
      endcase
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap   <= 0;
      end else begin
         if (req_valid && !req_stall) apply_command(on_bus);
         if (!req_valid || !req_stall) begin
            if (req_gap > 0) begin
               req_valid <= 1'b0;
               req_gap   <= req_gap - 1;
            end else if (req_items.size() != 0) begin
               on_bus = req_items.pop_front();
               req_valid        <= 1'b1;
               req_cmd          <= on_bus.cmd;
               req_coord_x      <= on_bus.x;
               req_coord_y      <= on_bus.y;
               req_coord_z      <= on_bus.z;
               req_occupied_bit <= on_bus.occ;
               req_gap          <= pick_idle(req_gaps_on);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : watch_rsp
      face_result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_hold  <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (face_results.size() == 0) begin
               errors++;
               $display("%0t: unexpected item, face_mask %b voxel_present %b",
                        $time, rsp_face_mask, rsp_voxel_present);
            end else begin
               want = face_results.pop_front();
               if (rsp_face_mask !== want.mask) begin
                  errors++;
                  $display("%0t: face_mask expected %b got %b",
                           $time, want.mask, rsp_face_mask);
               end
               if (rsp_voxel_present !== want.present) begin
                  errors++;
                  $display("%0t: voxel_present expected %b got %b",
                           $time, want.present, rsp_voxel_present);
               end
            end
         end
         rsp_stall <= rsp_hold > 0;
         if (rsp_hold > 0) rsp_hold <= rsp_hold - 1;
         else if ($urandom_range(3) == 0) rsp_hold <= pick_idle(rsp_stalls_on);
      end
   end

   function automatic void push(logic [1:0] c, int x, int y, int z, int o);
      req_item_type it;
      it.cmd = c;
      it.x   = x[COORD_W-1:0];
      it.y   = y[COORD_W-1:0];
      it.z   = z[COORD_W-1:0];
      it.occ = o[0];
      req_items.push_back(it);
      n_pushed++;
   endfunction

   task automatic write_extent(int unsigned v);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v[EXTENT_W-1:0];
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      scan_extent = v;
      n_phases++;
   endtask

   task automatic drain();
      while (n_items != n_pushed || face_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic int near(int centre);
      int v;
      v = centre + $urandom_range(4) - 2;
      if (v < 0) v = 0;
      if (v > GRID - 1) v = GRID - 1;
      return v;
   endfunction

   task automatic random_phase(int unsigned extent, int count);
      int cx, cy, cz, edge_pos, density, r;
      write_extent(extent);
      req_gaps_on   = $urandom_range(2) != 0;
      rsp_stalls_on = $urandom_range(2) != 0;
      density  = $urandom_range(90, 10);
      edge_pos = extent > GRID - 1 ? GRID - 1 : extent;
      if ($urandom_range(3) == 0)
         push(CMD_FILL, $urandom_range(31), $urandom_range(31), $urandom_range(31),
              $urandom_range(1));
      for (int i = 0; i < count; i++) begin
         if (i % 16 == 0) begin
            // move the working region, often to the scan boundary
            cx = $urandom_range(1) ? edge_pos : $urandom_range(GRID - 1);
            cy = $urandom_range(1) ? edge_pos : $urandom_range(GRID - 1);
            cz = $urandom_range(1) ? edge_pos : $urandom_range(GRID - 1);
         end
         r = $urandom_range(99);
         if (r < 3)
            push(CMD_UNUSED, $urandom_range(31), $urandom_range(31), $urandom_range(31),
                 $urandom_range(1));
         else if (r < 12)
            push(r < 7 ? CMD_WRITE : CMD_QUERY, $urandom_range(31), $urandom_range(31),
                 $urandom_range(31), $urandom_range(1));
         else if (r < 55)
            push(CMD_WRITE, near(cx), near(cy), near(cz),
                 int'($urandom_range(99) < density));
         else
            push(CMD_QUERY, near(cx), near(cy), near(cz), $urandom_range(1));
      end
      drain();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // empty grid, full scan
      write_extent(32);
      push(CMD_QUERY, 0, 0, 0, 0);
      push(CMD_WRITE, 0, 0, 0, 1);
      push(CMD_QUERY, 0, 0, 0, 0);       // lone corner voxel, all faces
      push(CMD_WRITE, 1, 0, 0, 1);
      push(CMD_QUERY, 0, 0, 0, 1);
      push(CMD_QUERY, 1, 0, 0, 0);
      push(CMD_WRITE, 31, 31, 31, 1);
      push(CMD_QUERY, 31, 31, 31, 0);
      push(CMD_UNUSED, 31, 31, 30, 1);   // unused command, no effect
      push(CMD_QUERY, 31, 31, 30, 0);
      push(CMD_WRITE, 1, 0, 0, 0);
      push(CMD_QUERY, 0, 0, 0, 0);
      push(CMD_WRITE, 1, 0, 0, 1);
      drain();

      // occupied neighbour beyond the scan still hides the face
      write_extent(1);
      push(CMD_QUERY, 0, 0, 0, 0);
      push(CMD_QUERY, 1, 0, 0, 0);
      drain();

      write_extent(0);
      push(CMD_QUERY, 0, 0, 0, 1);
      drain();

      // fill ignores its coordinates and bit
      write_extent(63);
      push(CMD_QUERY, 31, 31, 31, 0);
      push(CMD_FILL, 7, 9, 3, 0);
      push(CMD_QUERY, 0, 0, 0, 0);
      push(CMD_QUERY, 15, 15, 15, 0);
      push(CMD_QUERY, 31, 31, 31, 0);
      push(CMD_WRITE, 15, 15, 16, 0);
      push(CMD_QUERY, 15, 15, 15, 0);
      push(CMD_QUERY, 15, 15, 16, 0);
      drain();

      random_phase(32, 48);
      random_phase(31, 48);
      random_phase(1, 40);
      random_phase(63, 48);
      random_phase(0, 32);
      random_phase(17, 48);
      random_phase($urandom_range(63), 48);
      random_phase(32, 64);

      $display("Run covered %0d items under %0d scan_extent settings: %0d queries",
               n_items, n_phases, n_queries);
      $display("(%0d on solid voxels), %0d writes and %0d fills.",
               n_present, n_writes, n_fills);
      if (errors == 0 && face_results.size() == 0)
         $display("** voxel_exposed_face_mask: PASSED **");
      else
         $display("** voxel_exposed_face_mask: FAILED **");
      $finish;
   end

   initial begin
      #(5_000_000);
      $display("Timeout with %0d items still expected", face_results.size());
      $display("** voxel_exposed_face_mask: FAILED **");
      $finish;
   end

endmodule
